/* hw/rtl/pds_pkg.sv */
// ----------------------------------------------------------------------------
// pds_pkg
// Shared types and codes for the periodic deadline scheduler.
// ----------------------------------------------------------------------------
package pds_pkg;

	localparam int ID_W = 16;
	localparam int PER_W = 16;
	localparam int DUE_W = 48;
	localparam int ACT_W = 2;
	localparam int STS_W = 2;

	localparam logic [ACT_W-1:0] ACT_CLEAR = 2'd0;
	localparam logic [ACT_W-1:0] ACT_REG = 2'd1;
	localparam logic [ACT_W-1:0] ACT_SERVE = 2'd2;

	localparam logic [STS_W-1:0] STS_OK = 2'd0;
	localparam logic [STS_W-1:0] STS_EMPTY = 2'd1;
	localparam logic [STS_W-1:0] STS_FULL = 2'd2;

	// controller -> datapath
	typedef struct packed {
		logic load;      // capture input item
		logic clear;     // empty the table
		logic append;    // write new entry at count
		logic scan_start;// reset scan state, issue read of slot 0
		logic scan_step; // compare read entry, issue next read
		logic advance;   // write back due time of best slot
		logic resp;      // load result register
		logic [STS_W-1:0] sts;
		logic ok_serve;  // result carries best id
	} pds_cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic [ACT_W-1:0] action;
		logic empty;
		logic full;
		logic scan_last; // the entry being compared is the last one
	} pds_sts_t;

endpackage

/* hw/rtl/pds_if.sv */
// ----------------------------------------------------------------------------
// pds_if
// Valid/ready channel carrying one payload beat.
// ----------------------------------------------------------------------------
interface pds_if #(parameter type T = logic);
	logic valid;
	logic ready;
	T data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

/* hw/rtl/pds_dp.sv */
// ----------------------------------------------------------------------------
// pds_dp
// Datapath: client table memory, sequential minimum scan, result register.
// ----------------------------------------------------------------------------
module pds_dp import pds_pkg::*; #(
	parameter int CAPACITY = 64
) (
	input logic clk,
	input logic arst_n,
	input pds_cmd_t cmd,
	output pds_sts_t sts,
	input logic [ACT_W-1:0] in_action,
	input logic [ID_W-1:0] in_id,
	input logic [PER_W-1:0] in_period,
	output logic [ID_W-1:0] res_id,
	output logic [STS_W-1:0] res_status
);
	localparam int AW = $clog2(CAPACITY);
	localparam int CW = $clog2(CAPACITY + 1);
	localparam int EW = DUE_W + ID_W + PER_W;

	logic [EW-1:0] mem [CAPACITY];
	logic [EW-1:0] rd_q;
	logic [ACT_W-1:0] act_q;
	logic [ID_W-1:0] id_q;
	logic [PER_W-1:0] per_q;
	logic [CW-1:0] count_q;
	logic [AW-1:0] rd_addr_q;  // slot whose data arrives in rd_q
	logic [AW-1:0] best_idx_q;
	logic [DUE_W-1:0] best_due_q;
	logic [ID_W-1:0] best_id_q;
	logic [PER_W-1:0] best_per_q;
	logic best_vld_q;

	logic [DUE_W-1:0] r_due;
	logic [ID_W-1:0] r_id;
	logic [PER_W-1:0] r_per;
	logic better;
	logic [AW-1:0] wr_addr;
	logic [EW-1:0] wr_data;
	logic wr_en;
	logic [AW-1:0] rd_addr_n;

	assign r_due = rd_q[EW-1 -: DUE_W];
	assign r_id = rd_q[ID_W+PER_W-1 -: ID_W];
	assign r_per = rd_q[PER_W-1:0];
	assign better = !best_vld_q || (r_due < best_due_q) ||
		(r_due == best_due_q && r_id < best_id_q);

	assign sts.action = act_q;
	assign sts.empty = (count_q == '0);
	assign sts.full = (count_q == CW'(CAPACITY));
	assign sts.scan_last = (CW'(rd_addr_q) == CW'(count_q - 1'b1));

	// pick one write port: append or advance
	always_comb begin
		wr_en = cmd.append || cmd.advance;
		if (cmd.append) begin
			wr_addr = count_q[AW-1:0];
			wr_data = {DUE_W'(per_q), id_q, per_q};
		end else begin
			wr_addr = better ? rd_addr_q : best_idx_q;
			wr_data = better ? {r_due + DUE_W'(r_per), r_id, r_per}
				: {best_due_q + DUE_W'(best_per_q), best_id_q, best_per_q};
		end
		rd_addr_n = cmd.scan_start ? '0 : rd_addr_q + 1'b1;
	end

	// table memory, one write and one registered read
	always_ff @(posedge clk) begin
		if (wr_en)
			mem[wr_addr] <= wr_data;
		if (cmd.scan_start || cmd.scan_step)
			rd_q <= mem[rd_addr_n];
	end

	// hold item and scan state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			best_vld_q <= 1'b0;
			rd_addr_q <= '0;
			act_q <= ACT_CLEAR;
		end else begin
			if (cmd.load)
				act_q <= in_action;
			if (cmd.clear)
				count_q <= '0;
			else if (cmd.append)
				count_q <= count_q + 1'b1;
			if (cmd.scan_start) begin
				best_vld_q <= 1'b0;
				rd_addr_q <= '0;
			end else if (cmd.scan_step) begin
				rd_addr_q <= rd_addr_n;
				if (better)
					best_vld_q <= 1'b1;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			id_q <= in_id;
			per_q <= in_period;
		end
		if (cmd.scan_step && better) begin
			best_idx_q <= rd_addr_q;
			best_due_q <= r_due;
			best_id_q <= r_id;
			best_per_q <= r_per;
		end
		if (cmd.resp) begin
			res_status <= cmd.sts;
			res_id <= cmd.ok_serve ? (better ? r_id : best_id_q) : '0;
		end
	end
endmodule

/* hw/rtl/pds_ctrl.sv */
// ----------------------------------------------------------------------------
// pds_ctrl
// Controller: accepts items, sequences the scan, hands off results.
// ----------------------------------------------------------------------------
module pds_ctrl import pds_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_ready,
	output logic out_valid,
	input logic out_ready,
	output pds_cmd_t cmd,
	input pds_sts_t sts
);
	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_EXEC = 2'd1;
	localparam logic [1:0] S_SCAN = 2'd2;

	logic [1:0] state_q, state_n;
	logic out_vld_q;
	logic resp;

	// items are accepted only in idle; the result register frees when empty or being taken
	assign in_ready = (state_q == S_IDLE);
	assign out_valid = out_vld_q;

	always_comb begin
		cmd = '0;
		state_n = state_q;
		resp = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				cmd.load = in_valid;
				if (in_valid)
					state_n = S_EXEC;
			end
			S_EXEC: begin
				if (!out_vld_q || out_ready) begin
					priority if (sts.action == ACT_CLEAR) begin
						cmd.clear = 1'b1;
						resp = 1'b1;
					end else if (sts.action == ACT_REG) begin
						cmd.append = !sts.full;
						cmd.sts = sts.full ? STS_FULL : STS_OK;
						resp = 1'b1;
					end else if (sts.action == ACT_SERVE) begin
						if (sts.empty) begin
							cmd.sts = STS_EMPTY;
							resp = 1'b1;
						end else begin
							cmd.scan_start = 1'b1;
							state_n = S_SCAN;
						end
					end else begin
						resp = 1'b1;
					end
					if (resp)
						state_n = S_IDLE;
				end
			end
			S_SCAN: begin
				cmd.scan_step = 1'b1;
				if (sts.scan_last) begin
					cmd.advance = 1'b1;
					cmd.ok_serve = 1'b1;
					resp = 1'b1;
					state_n = S_IDLE;
				end
			end
			default: state_n = S_IDLE;
		endcase
		cmd.resp = resp;
	end

	// hold state and result valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			out_vld_q <= 1'b0;
		end else begin
			state_q <= state_n;
			if (resp)
				out_vld_q <= 1'b1;
			else if (out_ready)
				out_vld_q <= 1'b0;
		end
	end
endmodule

/* hw/rtl/periodic_deadline_scheduler_unit.sv */
// Clear/register/error items give their result without a scan; a serve
// scans the table memory one entry per cycle through its registered read,
// so its result follows a pass over all N clients of the table.
// One item at a time: the next item is taken only after the previous
// result is registered, and an item waits while an earlier result is not taken.
// Reset clears the entry count and control state; table contents are
// undefined until written and never read before that.
// ----------------------------------------------------------------------------
// periodic_deadline_scheduler_unit
// Top level: periodic client table with earliest-due serving.
// ----------------------------------------------------------------------------
module periodic_deadline_scheduler_unit import pds_pkg::*; #(
	parameter int CAPACITY = 64
) (
	input logic clk,
	input logic arst_n,
	pds_if.sink item,
	pds_if.source result
);
	pds_cmd_t cmd;
	pds_sts_t sts;

	pds_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n),
		.in_valid(item.valid), .in_ready(item.ready),
		.out_valid(result.valid), .out_ready(result.ready),
		.cmd(cmd), .sts(sts)
	);

	pds_dp #(.CAPACITY(CAPACITY)) u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .sts(sts),
		.in_action(item.data.action), .in_id(item.data.client_id),
		.in_period(item.data.client_period),
		.res_id(result.data.served_id), .res_status(result.data.status)
	);
endmodule

/* hw/rtl/pds_checker.sv */
// ----------------------------------------------------------------------------
// pds_checker
// Port-level checks on the scheduler unit.
// ----------------------------------------------------------------------------
module pds_checker import pds_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic in_ready,
	input logic out_valid,
	input logic out_ready,
	input logic [ID_W-1:0] served_id,
	input logic [STS_W-1:0] status
);
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(served_id) && $stable(status))
		else $error("result changed while stalled");
	a_id_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status != STS_OK |-> served_id == '0)
		else $error("error result carries an id");
	a_sts_legal: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> status == STS_OK || status == STS_EMPTY || status == STS_FULL)
		else $error("illegal status");
	a_one_at_time: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("second item taken while busy");
endmodule

bind periodic_deadline_scheduler_unit pds_checker u_chk (
	.clk(clk), .arst_n(arst_n),
	.in_valid(item.valid), .in_ready(item.ready),
	.out_valid(result.valid), .out_ready(result.ready),
	.served_id(result.data.served_id), .status(result.data.status)
);

/* tb/tb_periodic_deadline_scheduler_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_periodic_deadline_scheduler_unit
// Self-checking bench for the periodic deadline scheduler. A directed table
// covers reset, errors, ties and odd periods. A random run follows that fills
// the table past capacity, serves deep into the schedule and clears it. Every
// response beat is checked against a typed result or an in-bench model of the client table.
// ----------------------------------------------------------------------------
module tb_periodic_deadline_scheduler_unit;
	import pds_pkg::*;

	localparam int SLOTS = 64;
	localparam int RANDOM_ITEMS = 1400;
	// unassigned action code: no effect on the table
	localparam logic [ACT_W-1:0] ACT_NONE = 2'd3;

	typedef struct packed {
		logic [ACT_W-1:0] action;
		logic [ID_W-1:0] client_id;
		logic [PER_W-1:0] client_period;
	} sched_req_t;

	typedef struct packed {
		logic [ID_W-1:0] served_id;
		logic [STS_W-1:0] status;
	} sched_rsp_t;

	typedef struct {
		sched_req_t req;
		bit typed;
		sched_rsp_t rsp;
	} dir_row_t;

	logic clk;
	logic arst_n;

	pds_if #(.T(sched_req_t)) item ();
	pds_if #(.T(sched_rsp_t)) result ();

	periodic_deadline_scheduler_unit #(.CAPACITY(SLOTS)) dut (
		.clk(clk),
		.arst_n(arst_n),
		.item(item.sink),
		.result(result.source)
	);

	// client table mirror
	logic [DUE_W-1:0] due_tbl [SLOTS];
	logic [ID_W-1:0] id_tbl [SLOTS];
	logic [PER_W-1:0] per_tbl [SLOTS];
	int n_clients;

	sched_rsp_t pending_rsp [$];
	int fail_cnt;
	int beats_in;
	int beats_out;
	int n_served;
	int n_empty;
	int n_full;
	int n_clear;
	bit hold_done;

	// clock
	initial clk = 1'b0;
	always #1 clk = ~clk;

	// drive all inputs known, hold reset
	initial begin
		arst_n = 1'b0;
		item.valid = 1'b0;
		item.data = '0;
		result.ready = 1'b0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
	end

	// apply one accepted request to the table mirror
	function automatic sched_rsp_t schedule_step(sched_req_t r);
		sched_rsp_t o;
		int best;
		o = '0;
		o.status = STS_OK;
		if (r.action == ACT_CLEAR) begin
			n_clients = 0;
			n_clear++;
		end else if (r.action == ACT_REG) begin
			if (n_clients >= SLOTS) begin
				o.status = STS_FULL;
				n_full++;
			end else begin
				due_tbl[n_clients] = DUE_W'(r.client_period);
				id_tbl[n_clients] = r.client_id;
				per_tbl[n_clients] = r.client_period;
				n_clients++;
			end
		end else if (r.action == ACT_SERVE) begin
			if (n_clients == 0) begin
				o.status = STS_EMPTY;
				n_empty++;
			end else begin
				best = 0;
				for (int i = 1; i < n_clients; i++) begin
					if (due_tbl[i] < due_tbl[best] ||
					    (due_tbl[i] == due_tbl[best] && id_tbl[i] < id_tbl[best]))
						best = i;
				end
				o.served_id = id_tbl[best];
				due_tbl[best] = due_tbl[best] + DUE_W'(per_tbl[best]);
				n_served++;
			end
		end
		return o;
	endfunction

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60) return 0;
		if (r < 94) return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	function automatic sched_req_t mk_req(logic [ACT_W-1:0] a, logic [ID_W-1:0] id,
		logic [PER_W-1:0] per);
		sched_req_t r;
		r.action = a;
		r.client_id = id;
		r.client_period = per;
		return r;
	endfunction

	function automatic logic [ID_W-1:0] rand_id(int unsigned hi);
		return ID_W'($urandom_range(0, hi));
	endfunction

	// random content: narrow ranges give ties, wide ones toggle every bit
	function automatic sched_req_t rand_reg();
		logic [ID_W-1:0] id;
		logic [PER_W-1:0] per;
		case ($urandom_range(0, 3))
			0: begin
				id = rand_id(65535);
				per = PER_W'($urandom_range(1, 65535));
			end
			1: begin
				id = rand_id(7);
				per = PER_W'($urandom_range(1, 8));
			end
			2: begin
				id = rand_id(65535);
				per = ($urandom_range(0, 19) == 0) ? '0 : PER_W'($urandom_range(1, 300));
			end
			default: begin
				id = rand_id(31);
				per = PER_W'($urandom_range(1, 1000));
			end
		endcase
		return mk_req(ACT_REG, id, per);
	endfunction

	bit idle_tx;

	// offer one beat and wait for acceptance; predict on accept
	task automatic send_beat(sched_req_t r, bit typed, sched_rsp_t typed_rsp);
		int gap;
		sched_rsp_t p;
		gap = idle_tx ? pick_gap() : 0;
		if (gap > 0) begin
			item.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		item.valid <= 1'b1;
		item.data <= r;
		@(posedge clk);
		while (!item.ready) @(posedge clk);
		p = schedule_step(r);
		pending_rsp.push_back(typed ? typed_rsp : p);
		beats_in++;
	endtask

	// stimulus
	initial begin
		dir_row_t rows [$];
		sched_rsp_t ok0;
		sched_rsp_t z;
		int seg;
		int len;
		ok0 = '0;
		ok0.status = STS_OK;
		z = '0;
		idle_tx = 1'b0;

		// directed table: typed results where obvious, model otherwise
		rows.push_back('{mk_req(ACT_SERVE, 16'h0, 16'h0), 1, '{16'h0, STS_EMPTY}});
		rows.push_back('{mk_req(ACT_NONE, 16'hFFFF, 16'hFFFF), 1, ok0});
		rows.push_back('{mk_req(ACT_CLEAR, 16'hFFFF, 16'hFFFF), 1, ok0});
		rows.push_back('{mk_req(ACT_REG, 16'hFFFF, 16'hFFFF), 1, ok0});
		rows.push_back('{mk_req(ACT_SERVE, 16'h0, 16'h0), 1, '{16'hFFFF, STS_OK}});
		rows.push_back('{mk_req(ACT_REG, 16'h0000, 16'h0001), 1, ok0});
		rows.push_back('{mk_req(ACT_REG, 16'h0007, 16'h0003), 1, ok0});
		rows.push_back('{mk_req(ACT_REG, 16'h0003, 16'h0003), 1, ok0});
		// duplicate id with equal period: lowest slot wins the tie
		rows.push_back('{mk_req(ACT_REG, 16'h0003, 16'h0003), 1, ok0});
		for (int i = 0; i < 7; i++)
			rows.push_back('{mk_req(ACT_SERVE, 16'h5A5A, 16'hA5A5), 0, z});
		// zero period stays due at time zero forever
		rows.push_back('{mk_req(ACT_REG, 16'h1234, 16'h0000), 1, ok0});
		rows.push_back('{mk_req(ACT_SERVE, 16'h0, 16'h0), 1, '{16'h1234, STS_OK}});
		rows.push_back('{mk_req(ACT_SERVE, 16'h0, 16'h0), 1, '{16'h1234, STS_OK}});
		rows.push_back('{mk_req(ACT_CLEAR, 16'h0, 16'h0), 1, ok0});
		rows.push_back('{mk_req(ACT_SERVE, 16'hFFFF, 16'hFFFF), 1, '{16'h0, STS_EMPTY}});
		rows.push_back('{mk_req(ACT_NONE, 16'h0, 16'h0), 1, ok0});

		@(posedge clk);
		while (!arst_n) @(posedge clk);
		foreach (rows[i]) send_beat(rows[i].req, rows[i].typed, rows[i].rsp);

		// random segments: fill past full, mixed service, clears and noise
		while (beats_in < RANDOM_ITEMS + rows.size()) begin
			idle_tx = ($urandom_range(0, 3) != 0);
			seg = $urandom_range(0, 9);
			if (seg < 2) begin
				len = $urandom_range(60, 70);
				for (int i = 0; i < len; i++) send_beat(rand_reg(), 0, z);
			end else if (seg < 8) begin
				len = $urandom_range(10, 40);
				for (int i = 0; i < len; i++) begin
					if ($urandom_range(0, 99) < 35)
						send_beat(rand_reg(), 0, z);
					else
						send_beat(mk_req(ACT_SERVE, rand_id(65535),
							PER_W'($urandom_range(0, 65535))), 0, z);
				end
			end else if (seg == 8) begin
				send_beat(mk_req(ACT_CLEAR, rand_id(65535),
					PER_W'($urandom_range(0, 65535))), 0, z);
			end else begin
				send_beat(mk_req(ACT_NONE, rand_id(65535),
					PER_W'($urandom_range(0, 65535))), 0, z);
			end
		end
		item.valid <= 1'b0;

		// drain, then allow a full-table scan of settle time
		while (pending_rsp.size() != 0) @(posedge clk);
		repeat (2 * SLOTS + 10) @(posedge clk);

		$display("Run: %0d requests, %0d responses; %0d serves, %0d empty, %0d full, %0d clears",
			beats_in, beats_out, n_served, n_empty, n_full, n_clear);
		$display("Covered table fill past capacity, ties, zero periods and back-pressure");
		if (fail_cnt == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

	// response ready: random stalls, one long hold-off to back up the input
	initial begin
		int cyc;
		int gap;
		cyc = 0;
		hold_done = 1'b0;
		@(posedge clk);
		while (!arst_n) @(posedge clk);
		forever begin
			if (!hold_done && beats_in > 300) begin
				result.ready <= 1'b0;
				for (int i = 0; i < 500; i++) @(posedge clk);
				hold_done = 1'b1;
			end
			cyc++;
			if ((cyc / 2000) % 3 == 2) begin
				result.ready <= 1'b1;
				@(posedge clk);
			end else begin
				gap = pick_gap();
				if (gap > 0) begin
					result.ready <= 1'b0;
					repeat (gap) @(posedge clk);
				end
				result.ready <= 1'b1;
				@(posedge clk);
			end
		end
	end

	// compare each response beat against the oldest expectation
	always @(posedge clk) begin
		sched_rsp_t want;
		if (arst_n && result.valid && result.ready) begin
			beats_out++;
			if (pending_rsp.size() == 0) begin
				$error("unexpected response beat: served_id=%h status=%0d",
					result.data.served_id, result.data.status);
				fail_cnt++;
			end else begin
				want = pending_rsp.pop_front();
				if (result.data.served_id !== want.served_id) begin
					$error("served_id mismatch: expected %h actual %h",
						want.served_id, result.data.served_id);
					fail_cnt++;
				end
				if (result.data.status !== want.status) begin
					$error("status mismatch: expected %0d actual %0d",
						want.status, result.data.status);
					fail_cnt++;
				end
			end
		end
	end

	// timeout
	initial begin
		#4ms;
		$display("*** FAILED ***");
		$finish;
	end

endmodule
